/* rtl/spf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the smallest-prime-factor sieve.
// ----------------------------------------------------------------------------
package spf_pkg;

   localparam int QUERY_BITS     = 16;   // width of query values and the limit
   localparam int EXP_BITS       = 4;
   localparam int MAX_RESULTS    = 6;    // results per factorize item, at most
   localparam int RES_CNT_BITS   = 3;
   localparam int DEF_VALUE_BITS = 16;
   localparam int DEF_SPF_BITS   = 8;
   localparam int DIV_CNT_BITS   = $clog2(QUERY_BITS);

   localparam logic [QUERY_BITS-1:0] LIMIT_RESET = '1;

   localparam logic ACT_BUILD  = 1'b0;
   localparam logic ACT_FACTOR = 1'b1;

   typedef enum logic [1:0] {
      KIND_DONE   = 2'd0,
      KIND_FACTOR = 2'd1,
      KIND_NONE   = 2'd2,
      KIND_RANGE  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [QUERY_BITS-1:0]   prime_factor;
      logic [EXP_BITS-1:0]     exponent;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* rtl/smallest_prime_factor_sieve_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve_top
// Smallest-prime-factor sieve with a factorizing query channel.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write the sieve limit (reset 65535) while the block is idle;
//            csr_ready is always high. A build uses the limit at its start.
//   req_*  : one item per handshake (valid high, stall low). Action build
//            sieves the table up to the limit and answers with one done item.
//            Action factorize answers with one item per distinct prime in
//            increasing order, rsp_last on the final one; values below two
//            and values beyond the last build's limit give one item.
//   rsp_*  : results leave through one output register; while rsp_stall is
//            high the item holds and the engine waits before its next result.
// Sequence (L = build limit):
//   build      : clears the table up to L, then visits each candidate
//                prime up to sqrt(L) and each prime's multiples from its
//                square up to L, paced by the one read and one write table port.
//   factorize  : a table lookup for each prime, then divisions on the serial
//                divider (one quotient bit a cycle) until a remainder is
//                nonzero or the quotient reaches one; rejected values skip both.
//   The next item is taken once the last result sits in the output
//   register. Reset clears the built flag; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module smallest_prime_factor_sieve_top import spf_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [QUERY_BITS-1:0] req_query_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [QUERY_BITS-1:0] rsp_prime_factor,
   output logic [EXP_BITS-1:0]   rsp_exponent,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [QUERY_BITS-1:0] csr_sieve_limit
);

   logic [QUERY_BITS-1:0] sieve_limit_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  eng_valid;
   rsp_type               eng_item;
   logic                  slot_free;

   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         sieve_limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         sieve_limit_ff <= csr_sieve_limit;
      end
   end

   spf_engine #(
      .VALUE_BITS (VALUE_BITS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_query_value (req_query_value),
      .sieve_limit     (sieve_limit_ff),
      .out_valid       (eng_valid),
      .out_item        (eng_item),
      .out_ready       (slot_free)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (eng_valid && slot_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= eng_item;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_prime_factor = rsp_ff.prime_factor;
   assign rsp_exponent     = rsp_ff.exponent;
   assign rsp_last         = rsp_ff.last;

   a_factor_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_FACTOR) |->
         rsp_exponent != '0 && rsp_prime_factor > QUERY_BITS'(1))
      else $error("factor item without a prime or exponent");

   a_single_item_kinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_FACTOR) |->
         rsp_last && rsp_prime_factor == '0 && rsp_exponent == '0)
      else $error("status item not last or carries a payload");

endmodule

/* rtl/spf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_div
// Serial restoring divider: one quotient bit per cycle over the QUERY_BITS-bit dividend.
// ----------------------------------------------------------------------------
module spf_div import spf_pkg::*; #(
   parameter int DIVISOR_BITS = DEF_SPF_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [QUERY_BITS-1:0]   dividend,
   input  logic [DIVISOR_BITS-1:0] divisor,
   output div_status_type          status,
   output logic [QUERY_BITS-1:0]   quotient,
   output logic [DIVISOR_BITS-1:0] remainder
);

   logic [QUERY_BITS-1:0]   quo_ff;
   logic [DIVISOR_BITS-1:0] rem_ff;
   logic [DIVISOR_BITS-1:0] dvs_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    busy_ff;
   logic                    done_ff;

   logic [DIVISOR_BITS:0]   partial;
   logic [DIVISOR_BITS:0]   diff;

   always_comb begin
      partial = {rem_ff, quo_ff[QUERY_BITS-1]};
      diff    = partial - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            cnt_ff  <= DIV_CNT_BITS'(QUERY_BITS - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // sign bit clear: the divisor fits into the partial remainder
            if (!diff[DIVISOR_BITS]) begin
               rem_ff <= diff[DIVISOR_BITS-1:0];
               quo_ff <= {quo_ff[QUERY_BITS-2:0], 1'b1};
            end else begin
               rem_ff <= partial[DIVISOR_BITS-1:0];
               quo_ff <= {quo_ff[QUERY_BITS-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - DIV_CNT_BITS'(1);
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

/* rtl/spf_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_engine
// Sieve table memory and the sequencer that builds it and factorizes from it.
// ----------------------------------------------------------------------------
module spf_engine import spf_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [QUERY_BITS-1:0] req_query_value,
   input  logic [QUERY_BITS-1:0] sieve_limit,
   output logic                  out_valid,
   output rsp_type               out_item,
   input  logic                  out_ready
);

   localparam int EFF_BITS  = (VALUE_BITS < QUERY_BITS) ? VALUE_BITS : QUERY_BITS;
   localparam int SPF_BITS  = (EFF_BITS + 1) / 2;
   localparam int P_BITS    = SPF_BITS + 1;
   localparam int WIDE_BITS = QUERY_BITS + 1;
   localparam int DEPTH     = 1 << VALUE_BITS;
   localparam int CAP_INT   = (VALUE_BITS < QUERY_BITS) ? ((1 << VALUE_BITS) - 1)
                                                        : ((1 << QUERY_BITS) - 1);
   localparam logic [QUERY_BITS-1:0] LIMIT_CAP = QUERY_BITS'(CAP_INT);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_P_ISSUE,
      ST_P_WAIT,
      ST_M_READ,
      ST_M_WRITE,
      ST_LOOKUP,
      ST_L_WAIT,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type               state_ff;
   logic [QUERY_BITS-1:0]   lim_ff;
   logic [WIDE_BITS-1:0]    m_ff;
   logic [P_BITS-1:0]       p_ff;
   logic [WIDE_BITS-1:0]    sq_ff;
   logic [QUERY_BITS-1:0]   v_ff;
   logic [SPF_BITS-1:0]     f_ff;
   logic [EXP_BITS-1:0]     e_ff;
   logic                    first_ff;
   logic [RES_CNT_BITS-1:0] n_ff;
   logic                    built_ff;
   logic [QUERY_BITS-1:0]   built_limit_ff;
   rsp_type                 pr_ff;

   // smallest prime factor table, zero = prime or cleared
   logic [SPF_BITS-1:0]     table_mem [DEPTH];
   logic [SPF_BITS-1:0]     tbl_rd_data_ff;
   logic                    tbl_rd_en;
   logic [VALUE_BITS-1:0]   tbl_rd_addr;
   logic                    tbl_wr_en;
   logic [VALUE_BITS-1:0]   tbl_wr_addr;
   logic [SPF_BITS-1:0]     tbl_wr_data;

   logic                    div_start;
   logic [QUERY_BITS-1:0]   div_dividend;
   logic [SPF_BITS-1:0]     div_divisor;
   div_status_type          div_stat;
   logic [QUERY_BITS-1:0]   div_quo;
   logic [SPF_BITS-1:0]     div_rem;

   logic [WIDE_BITS-1:0]    lim_wide;
   logic                    sweep_done;
   logic                    m_past;
   logic [EXP_BITS-1:0]     exp_inc;
   logic [WIDE_BITS-1:0]    sq_next;
   logic [P_BITS-1:0]       p_next;

   always_comb begin
      lim_wide   = WIDE_BITS'(lim_ff);
      sweep_done = sq_ff > lim_wide;
      m_past     = m_ff > lim_wide;
      exp_inc    = (e_ff == '1) ? e_ff : e_ff + EXP_BITS'(1);
      // (p+1)^2 = p^2 + 2p + 1
      sq_next    = sq_ff + WIDE_BITS'({p_ff, 1'b0}) + WIDE_BITS'(1);
      p_next     = p_ff + P_BITS'(1);
   end

   always_comb begin
      tbl_rd_en   = 1'b0;
      tbl_rd_addr = VALUE_BITS'(m_ff);
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = VALUE_BITS'(m_ff);
      tbl_wr_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            tbl_wr_en = 1'b1;
         end
         ST_P_ISSUE: begin
            tbl_rd_en   = !sweep_done;
            tbl_rd_addr = VALUE_BITS'(p_ff);
         end
         ST_M_READ: begin
            tbl_rd_en = !m_past;
         end
         ST_M_WRITE: begin
            tbl_wr_en   = (tbl_rd_data_ff == '0);
            tbl_wr_data = SPF_BITS'(p_ff);
         end
         ST_LOOKUP: begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = VALUE_BITS'(v_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_wr_en) begin
         table_mem[tbl_wr_addr] <= tbl_wr_data;
      end
      if (tbl_rd_en) begin
         tbl_rd_data_ff <= table_mem[tbl_rd_addr];
      end
   end

   always_comb begin
      div_start    = 1'b0;
      div_dividend = v_ff;
      div_divisor  = f_ff;
      if (state_ff == ST_L_WAIT && tbl_rd_data_ff != '0) begin
         div_start   = 1'b1;
         div_divisor = tbl_rd_data_ff;
      end else if (state_ff == ST_DIV && div_stat.done && (first_ff || div_rem == '0)
                   && div_quo > QUERY_BITS'(1)) begin
         div_start    = 1'b1;
         div_dividend = div_quo;
      end
   end

   spf_div #(
      .DIVISOR_BITS (SPF_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         built_ff       <= 1'b0;
         built_limit_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  pr_ff.prime_factor <= '0;
                  pr_ff.exponent     <= '0;
                  pr_ff.last         <= 1'b1;
                  if (req_action == ACT_BUILD) begin
                     lim_ff   <= (sieve_limit > LIMIT_CAP) ? LIMIT_CAP : sieve_limit;
                     m_ff     <= '0;
                     state_ff <= ST_CLEAR;
                  end else if (req_query_value < QUERY_BITS'(2)) begin
                     pr_ff.kind <= KIND_NONE;
                     state_ff   <= ST_EMIT;
                  end else if (!built_ff || req_query_value > built_limit_ff) begin
                     pr_ff.kind <= KIND_RANGE;
                     state_ff   <= ST_EMIT;
                  end else begin
                     v_ff     <= req_query_value;
                     n_ff     <= '0;
                     state_ff <= ST_LOOKUP;
                  end
               end
            end
            ST_CLEAR: begin
               if (m_ff == lim_wide) begin
                  p_ff     <= P_BITS'(2);
                  sq_ff    <= WIDE_BITS'(4);
                  state_ff <= ST_P_ISSUE;
               end else begin
                  m_ff <= m_ff + WIDE_BITS'(1);
               end
            end
            ST_P_ISSUE: begin
               if (sweep_done) begin
                  built_ff       <= 1'b1;
                  built_limit_ff <= lim_ff;
                  pr_ff.kind     <= KIND_DONE;
                  state_ff       <= ST_EMIT;
               end else begin
                  state_ff <= ST_P_WAIT;
               end
            end
            ST_P_WAIT: begin
               if (tbl_rd_data_ff == '0) begin
                  m_ff     <= sq_ff;
                  state_ff <= ST_M_READ;
               end else begin
                  p_ff     <= p_next;
                  sq_ff    <= sq_next;
                  state_ff <= ST_P_ISSUE;
               end
            end
            ST_M_READ: begin
               if (m_past) begin
                  p_ff     <= p_next;
                  sq_ff    <= sq_next;
                  state_ff <= ST_P_ISSUE;
               end else begin
                  state_ff <= ST_M_WRITE;
               end
            end
            ST_M_WRITE: begin
               m_ff     <= m_ff + WIDE_BITS'(p_ff);
               state_ff <= ST_M_READ;
            end
            ST_LOOKUP: begin
               state_ff <= ST_L_WAIT;
            end
            ST_L_WAIT: begin
               if (tbl_rd_data_ff == '0) begin
                  // what is left is prime
                  pr_ff.kind         <= KIND_FACTOR;
                  pr_ff.prime_factor <= v_ff;
                  pr_ff.exponent     <= EXP_BITS'(1);
                  pr_ff.last         <= 1'b1;
                  v_ff               <= QUERY_BITS'(1);
                  state_ff           <= ST_EMIT;
               end else begin
                  f_ff     <= tbl_rd_data_ff;
                  e_ff     <= '0;
                  first_ff <= 1'b1;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_stat.done) begin
                  pr_ff.kind         <= KIND_FACTOR;
                  pr_ff.prime_factor <= QUERY_BITS'(f_ff);
                  if (first_ff || div_rem == '0) begin
                     v_ff     <= div_quo;
                     e_ff     <= exp_inc;
                     first_ff <= 1'b0;
                     if (div_quo <= QUERY_BITS'(1)) begin
                        pr_ff.exponent <= exp_inc;
                        pr_ff.last     <= 1'b1;
                        state_ff       <= ST_EMIT;
                     end
                  end else begin
                     pr_ff.exponent <= e_ff;
                     pr_ff.last     <= (n_ff == RES_CNT_BITS'(MAX_RESULTS - 1));
                     state_ff       <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (out_ready) begin
                  n_ff     <= n_ff + RES_CNT_BITS'(1);
                  state_ff <= pr_ff.last ? ST_IDLE : ST_LOOKUP;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign out_valid = (state_ff == ST_EMIT);
   assign out_item  = pr_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_build_marks_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_ISSUE && sweep_done) |=> built_ff && built_limit_ff == lim_ff)
      else $error("finished build did not record its limit");

   a_pending_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid && $stable(pr_ff))
      else $error("pending result lost while output slot busy");

endmodule
